// File: src/depth_pixel_backprojection_assert.svh
// Assertion macros shared by the block's checker.
// No dependencies; include by bare file name.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define DPB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define DPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// same-cycle implication, never masked
`define DPB_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: src/dpb_pkg.sv
// Shared types and constants of the depth pixel back-projection block.
// No dependencies.
package dpb_pkg;

   localparam int MAX_WIDTH = 2048;

   // field widths fixed by the interface
   localparam int DEPTH_W = 16;
   localparam int PIX_W   = 11;
   localparam int POINT_W = 24;
   localparam int IMG_W_W = 12;
   localparam int CTR_W   = 15;
   localparam int RECIP_W = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // counter widths follow MAX_WIDTH
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = COL_W + 1;
   localparam int EXT_W = (CNT_W > IMG_W_W) ? CNT_W : IMG_W_W;
   localparam int MAG_W = (COL_W + 4 > CTR_W) ? COL_W + 4 : CTR_W;

   // product widths
   localparam int PD_W = MAG_W + DEPTH_W;
   localparam int P_W  = PD_W + RECIP_W;
   localparam int FRAC_W = 24;
   localparam int Q_W  = P_W - FRAC_W + 1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_FOCAL_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RECIP_FOCAL_Y = 3'd5;

   // register reset values
   localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
   localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT   = 16'd5000;
   localparam logic [CTR_W-1:0]   RST_CENTER_X      = 15'd6091;
   localparam logic [CTR_W-1:0]   RST_CENTER_Y      = 15'd3875;
   localparam logic [RECIP_W-1:0] RST_RECIP_FOCAL_X = 20'd44070;
   localparam logic [RECIP_W-1:0] RST_RECIP_FOCAL_Y = 20'd51911;

   typedef struct packed {
      logic [IMG_W_W-1:0] image_width;
      logic [DEPTH_W-1:0] depth_limit;
      logic [CTR_W-1:0]   center_x;
      logic [CTR_W-1:0]   center_y;
      logic [RECIP_W-1:0] recip_focal_x;
      logic [RECIP_W-1:0] recip_focal_y;
   } cfg_type;

   // one classified sample, ready for the multipliers
   typedef struct packed {
      logic               neg_x;
      logic [MAG_W-1:0]   mag_x;
      logic               neg_y;
      logic [MAG_W-1:0]   mag_y;
      logic [DEPTH_W-1:0] depth;
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type data;
   } push_type;

   typedef struct packed {
      logic      empty;
      entry_type data;
   } head_type;

endpackage

// File: src/dpb_ifs.sv
// Valid/ready stream interfaces for depth samples and projected points.
// Depends on dpb_pkg.
interface dpb_req_if import dpb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_mm;
   logic               frame_start;

   modport source (output valid, depth_mm, frame_start, input ready);
   modport sink   (input valid, depth_mm, frame_start, output ready);
endinterface

interface dpb_rsp_if import dpb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic        [DEPTH_W-1:0] point_z;
   logic        [PIX_W-1:0]   pixel_col;
   logic        [PIX_W-1:0]   pixel_row;

   modport source (output valid, point_x, point_y, point_z, pixel_col, pixel_row,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, pixel_col, pixel_row,
                   output ready);
endinterface

// File: src/dpb_front.sv
// Front end: pixel counters, depth check and offset magnitudes.
// Depends on dpb_pkg and dpb_req_if.
module dpb_front import dpb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dpb_req_if.sink   req,
   input  cfg_type   cfg,
   input  logic      q_full,
   output push_type  push
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] width_eff;
   logic [COL_W-1:0] col_base, col;
   logic [PIX_W-1:0] row;
   logic [CNT_W-1:0] col_next;
   logic             accept;
   logic [MAG_W:0]   scaled_x, scaled_y, diff_x, diff_y;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      if (cfg.image_width == '0) begin
         width_eff = CNT_W'(1);
      end else if (EXT_W'(cfg.image_width) > EXT_W'(MAX_WIDTH)) begin
         width_eff = CNT_W'(MAX_WIDTH);
      end else begin
         width_eff = CNT_W'(cfg.image_width);
      end

      col_base = req.frame_start ? '0 : col_ff;
      row      = req.frame_start ? '0 : row_ff;
      col      = (CNT_W'(col_base) >= width_eff) ? '0 : col_base;
      col_next = CNT_W'(col) + CNT_W'(1);

      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = row + PIX_W'(1);
      end else begin
         col_in = COL_W'(col_next);
         row_in = row;
      end

      scaled_x = (MAG_W+1)'(col) << 4;
      scaled_y = (MAG_W+1)'(row) << 4;
      diff_x   = scaled_x - (MAG_W+1)'(cfg.center_x);
      diff_y   = scaled_y - (MAG_W+1)'(cfg.center_y);

      push.data.neg_x = diff_x[MAG_W];
      push.data.mag_x = diff_x[MAG_W] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
      push.data.neg_y = diff_y[MAG_W];
      push.data.mag_y = diff_y[MAG_W] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
      push.data.depth = req.depth_mm;
      push.data.col   = PIX_W'(col);
      push.data.row   = row;
      push.push       = accept && (req.depth_mm != '0) && (req.depth_mm <= cfg.depth_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: src/dpb_queue.sv
// Short FIFO between the front end and the multiply pipeline.
// Depends on dpb_pkg.
module dpb_queue import dpb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output head_type head
);

   entry_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.data  = mem[rd_ptr_ff];
   assign do_pop     = pop && !head.empty;

   always_comb begin
      count_in = count_ff;
      if (push.push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push.push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)    rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

// File: src/dpb_back.sv
// Back end: offset*depth, times reciprocal, round and saturate.
// Depends on dpb_pkg and dpb_rsp_if.
module dpb_back import dpb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  head_type  head,
   output logic      pop,
   dpb_rsp_if.source rsp
);

   localparam logic [Q_W-1:0] POS_MAX = Q_W'(24'h7FFFFF);
   localparam logic [Q_W-1:0] NEG_MAX = Q_W'(25'h800000);
   localparam logic [P_W-1:0] HALF    = P_W'(1) << (FRAC_W - 1);

   logic               en;
   // stage 1
   logic               s1_valid_ff;
   logic               s1_neg_x_ff, s1_neg_y_ff;
   logic [PD_W-1:0]    s1_pd_x_ff, s1_pd_y_ff, s1_pd_x_in, s1_pd_y_in;
   logic [DEPTH_W-1:0] s1_depth_ff;
   logic [PIX_W-1:0]   s1_col_ff, s1_row_ff;
   // stage 2
   logic               s2_valid_ff;
   logic               s2_neg_x_ff, s2_neg_y_ff;
   logic [P_W-1:0]     s2_p_x_ff, s2_p_y_ff, s2_p_x_in, s2_p_y_in;
   logic [DEPTH_W-1:0] s2_depth_ff;
   logic [PIX_W-1:0]   s2_col_ff, s2_row_ff;
   // output
   logic               out_valid_ff;
   logic [POINT_W-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic [DEPTH_W-1:0] out_z_ff;
   logic [PIX_W-1:0]   out_col_ff, out_row_ff;

   function automatic logic [POINT_W-1:0] round_sat(input logic neg, input logic [P_W-1:0] p);
      logic [P_W:0]   sum;
      logic [Q_W-1:0] q;
      logic [POINT_W-1:0] r;
      sum = (P_W+1)'(p) + (P_W+1)'(HALF);
      q   = Q_W'(sum >> FRAC_W);
      if (neg) begin
         r = (q > NEG_MAX) ? POINT_W'(24'h800000) : POINT_W'(-q);
      end else begin
         r = (q > POS_MAX) ? POINT_W'(24'h7FFFFF) : POINT_W'(q);
      end
      return r;
   endfunction

   // whole pipeline moves when the output slot is free or being taken
   assign en  = !out_valid_ff || rsp.ready;
   assign pop = en && !head.empty;

   always_comb begin
      s1_pd_x_in = PD_W'(head.data.mag_x) * PD_W'(head.data.depth);
      s1_pd_y_in = PD_W'(head.data.mag_y) * PD_W'(head.data.depth);
      s2_p_x_in  = P_W'(s1_pd_x_ff) * P_W'(cfg.recip_focal_x);
      s2_p_y_in  = P_W'(s1_pd_y_ff) * P_W'(cfg.recip_focal_y);
      out_x_in   = round_sat(s2_neg_x_ff, s2_p_x_ff);
      out_y_in   = round_sat(s2_neg_y_ff, s2_p_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= !head.empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_neg_x_ff <= head.data.neg_x;
         s1_neg_y_ff <= head.data.neg_y;
         s1_pd_x_ff  <= s1_pd_x_in;
         s1_pd_y_ff  <= s1_pd_y_in;
         s1_depth_ff <= head.data.depth;
         s1_col_ff   <= head.data.col;
         s1_row_ff   <= head.data.row;

         s2_neg_x_ff <= s1_neg_x_ff;
         s2_neg_y_ff <= s1_neg_y_ff;
         s2_p_x_ff   <= s2_p_x_in;
         s2_p_y_ff   <= s2_p_y_in;
         s2_depth_ff <= s1_depth_ff;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;

         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_z_ff    <= s2_depth_ff;
         out_col_ff  <= s2_col_ff;
         out_row_ff  <= s2_row_ff;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.point_x   = out_x_ff;
   assign rsp.point_y   = out_y_ff;
   assign rsp.point_z   = out_z_ff;
   assign rsp.pixel_col = out_col_ff;
   assign rsp.pixel_row = out_row_ff;

endmodule

// File: src/depth_pixel_backprojection.sv
// Depth pixel back-projection top level: config registers, front, queue, back.
// Throughput: one sample per cycle while rsp_if is not stalled; set by the single-issue
//   front end and the 3-stage multiply pipeline (offset*depth, *reciprocal, round/saturate).
// Reset: synchronous, active high; clears counters, queue, pipeline valids and
//   restores register defaults.
module depth_pixel_backprojection import dpb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dpb_req_if.sink               req_if,
   dpb_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   // Register file. Values are truncated to register width; unknown
   // indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.depth_limit   <= RST_DEPTH_LIMIT;
         cfg_ff.center_x      <= RST_CENTER_X;
         cfg_ff.center_y      <= RST_CENTER_Y;
         cfg_ff.recip_focal_x <= RST_RECIP_FOCAL_X;
         cfg_ff.recip_focal_y <= RST_RECIP_FOCAL_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_wdata[IMG_W_W-1:0];
            CSR_DEPTH_LIMIT:   cfg_ff.depth_limit   <= csr_wdata[DEPTH_W-1:0];
            CSR_CENTER_X:      cfg_ff.center_x      <= csr_wdata[CTR_W-1:0];
            CSR_CENTER_Y:      cfg_ff.center_y      <= csr_wdata[CTR_W-1:0];
            CSR_RECIP_FOCAL_X: cfg_ff.recip_focal_x <= csr_wdata[RECIP_W-1:0];
            CSR_RECIP_FOCAL_Y: cfg_ff.recip_focal_y <= csr_wdata[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: counts pixels on every transaction, pushes only in-range depths.
   dpb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .push   (push)
   );

   // Decouples the sample stream from output back-pressure.
   dpb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   // Back: two registered multiplies then rounding into the output register.
   dpb_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_if)
   );

endmodule

// File: src/dpb_checker.sv
// Port-level checker for depth_pixel_backprojection, attached by bind.
// Depends on depth_pixel_backprojection_assert.svh and dpb_pkg.
`include "depth_pixel_backprojection_assert.svh"
module dpb_checker import dpb_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [POINT_W-1:0] point_x,
   input logic        [DEPTH_W-1:0] point_z,
   input logic        [PIX_W-1:0]   pixel_col
);

   `DPB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
   `DPB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(point_x) && $stable(point_z) && $stable(pixel_col), "rsp payload changed while stalled")
   `DPB_ASSERT_IMPL(a_z_nonzero, clock, reset, rsp_valid, point_z != '0, "point with zero depth")
   `DPB_ASSERT_ALWAYS(a_reset_clear, clock, $past(reset), !rsp_valid, "rsp valid right after reset")

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .point_x   (rsp_if.point_x),
   .point_z   (rsp_if.point_z),
   .pixel_col (rsp_if.pixel_col)
);

// File: tb/depth_pixel_backprojection_test.sv
// Testbench for depth_pixel_backprojection: a directed table, then phases of random raster
// streams, with every point checked against a typed-in point or a local back-projection predictor.
// Depends on dpb_pkg, the dpb_req_if/dpb_rsp_if interfaces and the block itself.
module depth_pixel_backprojection_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dpb_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Run parameters
   // ---------------------------------------------------------------------------------------
   localparam int RESET_CYCLES    = 8;
   localparam int IDLE_PCT        = 7;     // chance per cycle that a side idles
   localparam int MAX_GAP         = 3;     // longest sender pause, in cycles
   localparam int HOLD_OFF_CYCLES = 300;   // receiver back-pressure burst
   localparam int SETTLE_CYCLES   = 8;     // pipeline is 3 deep; covers dropped samples in flight
   localparam int DRAIN_CYCLES    = 20;
   // No-accept limit: the hold-off burst plus settle time is well under this.
   localparam int WATCHDOG_LIMIT  = 3000;

   localparam int PHASES      = 9;
   localparam int TALL_ITEMS  = 900;       // one pixel per row, a long run of rows
   localparam int WIDE_ITEMS  = 300;       // widest image, long enough to saturate x
   localparam int PHASE_ITEMS = 100;

   // indexes the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic signed [POINT_W-1:0] POINT_MIN = 24'sh800000;
   localparam logic signed [POINT_W-1:0] POINT_MAX = 24'sh7FFFFF;

   // ---------------------------------------------------------------------------------------
   // Types
   // ---------------------------------------------------------------------------------------
   typedef struct packed {
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
      logic [DEPTH_W-1:0]        point_z;
      logic [PIX_W-1:0]          pixel_col;
      logic [PIX_W-1:0]          pixel_row;
   } point_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   // how the point of a sample is checked: from the predictor, typed in, or none at all
   typedef enum logic [1:0] {EXP_MODEL, EXP_POINT, EXP_NONE} point_check_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_sel;
      logic [CSR_DATA_W-1:0] csr_value;
      logic [DEPTH_W-1:0]    depth;
      logic                  frame_start;
      point_check_type       check;
      point_type             want;
   } step_row_type;

   localparam point_type NO_POINT = '0;

   // ---------------------------------------------------------------------------------------
   // Directed table. Points are typed in where they follow directly from the reset values,
   // saturation or zero reciprocals; the rest go through the predictor.
   // ---------------------------------------------------------------------------------------
   localparam step_row_type DIRECTED_ROWS [29] = '{
      // reset config: first pixel of a frame, zero depth, just above/at the limit, max depth
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd1, 1'b1, EXP_POINT,
        '{-24'sd16, -24'sd12, 16'd1, 11'd0, 11'd0}},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd0,     1'b0, EXP_NONE,  NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd5001,  1'b0, EXP_NONE,  NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd5000,  1'b0, EXP_MODEL, NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'hFFFF,  1'b0, EXP_NONE,  NO_POINT},
      // all ones everywhere: width masks to 4095 and clamps, centers and reciprocals max out
      '{ROW_CSR, CSR_IMAGE_WIDTH,   20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_DEPTH_LIMIT,   20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_CENTER_X,      20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_CENTER_Y,      20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_RECIP_FOCAL_X, 20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_RECIP_FOCAL_Y, 20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_SPARE_LO,      20'hFFFFF, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_SPARE_HI,      20'h00001, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      // far left/top of the principal point: both axes saturate negative
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'hFFFF, 1'b1, EXP_POINT,
        '{POINT_MIN, POINT_MIN, 16'hFFFF, 11'd0, 11'd0}},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd1,    1'b0, EXP_MODEL, NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'h8000, 1'b0, EXP_MODEL, NO_POINT},
      // all zeros: width acts as 1, zero limit drops everything
      '{ROW_CSR, CSR_IMAGE_WIDTH,   20'h0, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_DEPTH_LIMIT,   20'h0, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_CENTER_X,      20'h0, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_CENTER_Y,      20'h0, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_RECIP_FOCAL_X, 20'h0, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_CSR, CSR_RECIP_FOCAL_Y, 20'h0, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd1,    1'b1, EXP_NONE, NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'hFFFF, 1'b0, EXP_NONE, NO_POINT},
      // limit of 1 mm: every pixel is a new row, zero reciprocals give a zero point
      '{ROW_CSR, CSR_DEPTH_LIMIT,   20'h1, 16'd0, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd1, 1'b1, EXP_POINT,
        '{24'sd0, 24'sd0, 16'd1, 11'd0, 11'd0}},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd1, 1'b0, EXP_POINT,
        '{24'sd0, 24'sd0, 16'd1, 11'd0, 11'd1}},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd2, 1'b0, EXP_NONE, NO_POINT},
      '{ROW_SAMPLE, CSR_IMAGE_WIDTH, 20'h0, 16'd1, 1'b0, EXP_POINT,
        '{24'sd0, 24'sd0, 16'd1, 11'd0, 11'd3}}
   };

   // ---------------------------------------------------------------------------------------
   // Clock, reset, block ports
   // ---------------------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dpb_req_if req_if ();
   dpb_rsp_if rsp_if ();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   depth_pixel_backprojection i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor state: camera registers and raster position, as the block should hold them
   // ---------------------------------------------------------------------------------------
   logic [IMG_W_W-1:0] cur_width    = RST_IMAGE_WIDTH;
   logic [DEPTH_W-1:0] cur_limit    = RST_DEPTH_LIMIT;
   logic [CTR_W-1:0]   cur_center_x = RST_CENTER_X;
   logic [CTR_W-1:0]   cur_center_y = RST_CENTER_Y;
   logic [RECIP_W-1:0] cur_recip_x  = RST_RECIP_FOCAL_X;
   logic [RECIP_W-1:0] cur_recip_y  = RST_RECIP_FOCAL_Y;
   int unsigned        column_now   = 0;
   int unsigned        row_now      = 0;

   point_type expected_points [$];   // points still owed by the block, oldest first

   int  mismatches   = 0;
   int  quiet_cycles = 0;
   bit  no_gaps      = 1'b0;      // both sides stream without idling
   bit  hold_off_req = 1'b0;      // sender asks the receiver for one long stall

   // One axis: offset from the principal point in 1/16 pixel, times depth, times the
   // Q0.24 reciprocal; round half away from zero, then clamp to 24 bits signed.
   function automatic logic signed [POINT_W-1:0] project_axis(input int unsigned pos,
         input logic [CTR_W-1:0] center, input logic [DEPTH_W-1:0] d,
         input logic [RECIP_W-1:0] recip);
      longint          offset;
      longint unsigned mag;
      longint unsigned q;
      offset = longint'(pos) * 16 - longint'(center);
      mag    = (offset < 0) ? -offset : offset;
      q      = (mag * d * recip + (64'd1 << 23)) >> 24;
      if (offset < 0)
         return (q > 64'd8388608) ? POINT_MIN : POINT_W'(-q);
      return (q > 64'd8388607) ? POINT_MAX : POINT_W'(q);
   endfunction

   // Advances the raster position by one sample; returns 1 if the sample yields a point.
   function automatic bit backproject(input logic [DEPTH_W-1:0] d, input logic frame_start,
         output point_type pt);
      int unsigned span;
      int unsigned col;
      int unsigned row;
      span = cur_width;
      if (span == 0) span = 1;
      if (span > MAX_WIDTH) span = MAX_WIDTH;
      if (frame_start) begin
         column_now = 0;
         row_now    = 0;
      end
      if (column_now >= span) column_now = 0;
      col = column_now;
      row = row_now;
      pt.point_x   = project_axis(col, cur_center_x, d, cur_recip_x);
      pt.point_y   = project_axis(row, cur_center_y, d, cur_recip_y);
      pt.point_z   = d;
      pt.pixel_col = PIX_W'(col);
      pt.pixel_row = PIX_W'(row);
      if (col + 1 >= span) begin
         column_now = 0;
         row_now    = (row + 1) % 2048;
      end else begin
         column_now = col + 1;
      end
      return (d != 0) && (d <= cur_limit);
   endfunction

   function automatic string point_text(input point_type p);
      return $sformatf("x=%0d y=%0d z=%0d col=%0d row=%0d", $signed(p.point_x),
         $signed(p.point_y), p.point_z, p.pixel_col, p.pixel_row);
   endfunction

   function automatic void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
   endfunction

   // register value with random junk above its width; the block must mask it off
   function automatic logic [CSR_DATA_W-1:0] dirty(input int unsigned value, input int w);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      return (junk << w) | CSR_DATA_W'(value);
   endfunction

   function automatic int unsigned pick_center(input int unsigned span);
      case ($urandom_range(3))
         0:       return $urandom_range(32767);
         1:       return 0;
         2:       return 32767;
         default: return $urandom_range((span * 16 > 32767) ? 32767 : span * 16);
      endcase
   endfunction

   function automatic int unsigned pick_recip();
      case ($urandom_range(3))
         0:       return $urandom_range(20'hFFFFF);
         1:       return 0;
         2:       return 20'hFFFFF;
         default: return $urandom_range(60000, 30000);   // focal lengths of a few hundred px
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers (inputs change on the falling edge)
   // ---------------------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] sel,
         input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      // block is idle here, so the predictor can take the value right away
      case (sel)
         CSR_IMAGE_WIDTH:   cur_width    = value[IMG_W_W-1:0];
         CSR_DEPTH_LIMIT:   cur_limit    = value[DEPTH_W-1:0];
         CSR_CENTER_X:      cur_center_x = value[CTR_W-1:0];
         CSR_CENTER_Y:      cur_center_y = value[CTR_W-1:0];
         CSR_RECIP_FOCAL_X: cur_recip_x  = value[RECIP_W-1:0];
         CSR_RECIP_FOCAL_Y: cur_recip_y  = value[RECIP_W-1:0];
         default: ;
      endcase
   endtask

   // Offers one depth transaction, with an occasional random pause in front of it, and
   // books the expected point at the edge where it is accepted.
   task automatic offer_sample(input step_row_type r);
      point_type pt;
      bit        has_point;
      @(negedge clock);
      if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid       <= 1'b0;
         req_if.depth_mm    <= DEPTH_W'($urandom);
         req_if.frame_start <= 1'($urandom);
         repeat ($urandom_range(MAX_GAP, 1)) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.depth_mm    <= r.depth;
      req_if.frame_start <= r.frame_start;
      do @(posedge clock); while (!req_if.ready);
      has_point = backproject(r.depth, r.frame_start, pt);
      if (r.check == EXP_POINT)
         expected_points = {expected_points, r.want};
      else if (r.check == EXP_MODEL && has_point)
         expected_points = {expected_points, pt};
   endtask

   // Stops offering and waits until every point is back and the pipeline has emptied.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver: random ready, plus one long stall on request, counted here
   // ---------------------------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Point checker: every accepted point against the oldest one owed
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      point_type got;
      point_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.point_x, rsp_if.point_y, rsp_if.point_z, rsp_if.pixel_col,
                 rsp_if.pixel_row};
         if (expected_points.size() == 0) begin
            flag_mismatch({"unexpected point ", point_text(got)});
         end else begin
            want = expected_points.pop_front();
            if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                got.point_z !== want.point_z || got.pixel_col !== want.pixel_col ||
                got.pixel_row !== want.pixel_row)
               flag_mismatch({"expected ", point_text(want), ", got ", point_text(got)});
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: too long without a transaction on either channel ends the run
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      step_row_type       sample;
      int unsigned        span;
      int unsigned        items;
      int unsigned        pick;
      logic [DEPTH_W-1:0] limit;
      bit                 csr_open;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_IMAGE_WIDTH;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.depth_mm    = '0;
      req_if.frame_start = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. A run of register rows is written only once the block has drained.
      csr_open = 1'b0;
      foreach (DIRECTED_ROWS[n]) begin
         if (DIRECTED_ROWS[n].kind == ROW_CSR) begin
            if (!csr_open) wait_drained();
            csr_open = 1'b1;
            csr_write(DIRECTED_ROWS[n].csr_sel, DIRECTED_ROWS[n].csr_value);
         end else begin
            if (csr_open) begin
               @(negedge clock);
               csr_wr_en <= 1'b0;
            end
            csr_open = 1'b0;
            offer_sample(DIRECTED_ROWS[n]);
         end
      end

      // Random phases, each a fresh camera setup and one frame of raster data.
      //   phase 0: one pixel per row, a long run of rows
      //   phase 1: widest image, centered at 0 with max reciprocal, so x saturates positive
      //   phase 2: both sides stream without idling
      //   phase 3: receiver stalls for a long burst while the sender keeps offering
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();   // also the sender's pause until every point is back
         no_gaps = (phase == 2);

         if (phase == 0)                   span = 1;
         else if (phase == 1)              span = $urandom_range(1) ? MAX_WIDTH : 4095;
         else if ($urandom_range(7) == 0)  span = $urandom_range(1);
         else                              span = $urandom_range(48, 2);

         case ($urandom_range(3))
            0:       limit = 16'hFFFF;
            1:       limit = DEPTH_W'($urandom_range(16'hFFFF, 1));
            2:       limit = DEPTH_W'($urandom_range(2000, 1));
            default: limit = RST_DEPTH_LIMIT;
         endcase
         if (phase == 1) limit = 16'hFFFF;

         csr_write(CSR_IMAGE_WIDTH, dirty(span, IMG_W_W));
         csr_write(CSR_DEPTH_LIMIT, dirty(limit, DEPTH_W));
         csr_write(CSR_CENTER_X, dirty((phase == 1) ? 0 : pick_center(span), CTR_W));
         csr_write(CSR_CENTER_Y, dirty(pick_center(span), CTR_W));
         csr_write(CSR_RECIP_FOCAL_X, dirty((phase == 1) ? 20'hFFFFF : pick_recip(), RECIP_W));
         csr_write(CSR_RECIP_FOCAL_Y, dirty(pick_recip(), RECIP_W));
         csr_write($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, CSR_DATA_W'($urandom));
         @(negedge clock);
         csr_wr_en <= 1'b0;

         if (phase == 3) hold_off_req = 1'b1;

         items = (phase == 0) ? TALL_ITEMS : (phase == 1) ? WIDE_ITEMS : PHASE_ITEMS;
         for (int k = 0; k < items; k++) begin
            sample.kind        = ROW_SAMPLE;
            sample.csr_sel     = CSR_IMAGE_WIDTH;
            sample.csr_value   = '0;
            sample.check       = EXP_MODEL;
            sample.want        = NO_POINT;
            // well-formed frame, with a stray frame start now and then
            sample.frame_start = (k == 0) || (phase != 0 && $urandom_range(99) < 2);
            pick = $urandom_range(99);
            if (pick < 70)
               sample.depth = DEPTH_W'($urandom_range(cur_limit, 1));
            else if (pick < 80)
               sample.depth = '0;
            else if (pick < 90 && cur_limit < 16'hFFFF)
               sample.depth = DEPTH_W'($urandom_range(16'hFFFF, cur_limit + 1));
            else
               sample.depth = DEPTH_W'($urandom);
            offer_sample(sample);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_points.size() != 0)
         flag_mismatch($sformatf("%0d points never arrived", expected_points.size()));

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
